// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks, clocked on clk; all but CHK_NEXT are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");

// When the first expression holds, the second holds in the same cycle.
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// When the first expression holds, the second holds in the next cycle.
`define CHK_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/jtl_pkg.sv
// ----------------------------------------------------------------------------
// JSON token lexer package
// Item types, token and mode codes, character constants and the idle lexer.
// ----------------------------------------------------------------------------
package jtl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_INT  = 2'd2,
    MODE_FRAC = 2'd3
  } lex_mode_t;

  typedef enum logic [3:0] {
    TT_EOF      = 4'd0,
    TT_LBRACE   = 4'd1,
    TT_RBRACE   = 4'd2,
    TT_LBRACKET = 4'd3,
    TT_RBRACKET = 4'd4,
    TT_COMMA    = 4'd5,
    TT_COLON    = 4'd6,
    TT_STRING   = 4'd7,
    TT_NUMBER   = 4'd8,
    TT_UNDEF    = 4'd9,
    TT_ERROR    = 4'd10
  } token_type_t;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result queue depth; it must hold two items' worth of results in flight.
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       at_end;
  } lex_in_t;

  typedef struct packed {
    token_type_t token_type;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        token_done;
    logic        last;
  } lex_out_t;

  typedef struct packed {
    logic      hit;
    lex_out_t  res;
    lex_mode_t mode;
  } idle_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Lexes one item from idle mode: at most one result and the mode after it.
  function automatic idle_res_t lex_idle(input logic [7:0] c, input logic end_mark);
    idle_res_t r;
    r          = '0;
    r.mode     = MODE_IDLE;
    r.hit      = 1'b1;
    r.res.token_done = 1'b1;
    r.res.token_type = TT_UNDEF;
    if (end_mark) begin
      r.res.token_type = TT_EOF;
    end else begin
      unique case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_CR: r.hit = 1'b0;
        CH_QUOTE: begin
          r.hit  = 1'b0;
          r.mode = MODE_STR;
        end
        CH_LBRACE: r.res.token_type = TT_LBRACE;
        CH_RBRACE: r.res.token_type = TT_RBRACE;
        CH_LBRACK: r.res.token_type = TT_LBRACKET;
        CH_RBRACK: r.res.token_type = TT_RBRACKET;
        CH_COMMA:  r.res.token_type = TT_COMMA;
        CH_COLON:  r.res.token_type = TT_COLON;
        default: begin
          if (is_digit(c)) begin
            r.res.token_type = TT_NUMBER;
            r.res.token_done = 1'b0;
            r.mode           = MODE_INT;
          end
        end
      endcase
      if (r.res.token_type != TT_UNDEF) begin
        r.res.text_byte = c;
        r.res.has_byte  = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/json_token_lexer.sv
// ----------------------------------------------------------------------------
// JSON token lexer
// Streaming lexer: one byte or end mark in, zero to two token results out.
// ----------------------------------------------------------------------------
//
//   Channel  Valid      Stall      Payload   Direction
//   src      src_valid  src_stall  src_item  bytes in (lex_in_t)
//   dst      dst_valid  dst_stall  dst_item  results out (lex_out_t)
//
// An accepted item is captured in an input register and lexed in the next
// cycle; its results are written into an eight-entry result queue.
// While src_stall is low the lexer takes one item per cycle; the sustained
// rate is limited only by the output, which moves one result per cycle, so
// an item that ends a number and gives a second token puts two results on
// the output.
// src_stall comes from registers only: it rises when the queue could not take
// two results for the item in flight plus two for a new one.
// Reset returns the mode to idle and empties the queue and input register.
//
module json_token_lexer
  import jtl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  lex_in_t  src_item,
  output logic     dst_valid,
  input  logic     dst_stall,
  output lex_out_t dst_item
);

  // Input register.
  logic      item_valid;
  lex_in_t   item;

  // Lexer state.
  lex_mode_t mode;
  lex_mode_t mode_next;

  // Results of the item in the input register.
  lex_out_t  res0;
  lex_out_t  res1;
  logic [1:0] res_count;

  // Result queue.
  lex_out_t        queue [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;
  logic [QAW:0]    count_next;

  logic src_take;
  logic dst_take;

  // The in-flight item may still push two results; a new one needs two more.
  assign src_stall = (count + {{(QAW-1){1'b0}}, item_valid, 1'b0}) >
                     (QAW+1)'(QDEPTH - 2);
  assign src_take  = src_valid && !src_stall;
  assign dst_valid = (count != '0);
  assign dst_take  = dst_valid && !dst_stall;
  assign dst_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= src_take;
    end
    if (src_take) begin
      item <= src_item;
    end
  end

  // Next mode, updated once per lexed item.
  always_comb begin
    idle_res_t idle;
    idle      = lex_idle(item.in_byte, item.at_end);
    mode_next = mode;
    unique case (mode)
      MODE_STR: begin
        if (item.at_end || item.in_byte == CH_QUOTE) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (!item.at_end && is_digit(item.in_byte)) begin
          mode_next = mode;
        end else if (!item.at_end && item.in_byte == CH_DOT && mode == MODE_INT) begin
          mode_next = MODE_FRAC;
        end else begin
          mode_next = idle.mode;
        end
      end
      MODE_IDLE: mode_next = idle.mode;
    endcase
  end

  // Results of the item; a number end is followed by the relexed byte.
  always_comb begin
    idle_res_t idle;
    idle      = lex_idle(item.in_byte, item.at_end);
    res0      = '0;
    res1      = '0;
    res_count = 2'd1;
    unique case (mode)
      MODE_STR: begin
        res0.token_type = TT_STRING;
        if (item.at_end) begin
          res0.token_type = TT_ERROR;
          res0.token_done = 1'b1;
        end else if (item.in_byte == CH_QUOTE) begin
          res0.token_done = 1'b1;
        end else begin
          res0.text_byte = item.in_byte;
          res0.has_byte  = 1'b1;
        end
      end
      MODE_INT, MODE_FRAC: begin
        res0.token_type = TT_NUMBER;
        if ((!item.at_end && is_digit(item.in_byte)) ||
            (!item.at_end && item.in_byte == CH_DOT && mode == MODE_INT)) begin
          res0.text_byte = item.in_byte;
          res0.has_byte  = 1'b1;
        end else begin
          res0.token_done = 1'b1;
          if (idle.hit) begin
            res1      = idle.res;
            res_count = 2'd2;
          end
        end
      end
      MODE_IDLE: begin
        res0      = idle.res;
        res_count = {1'b0, idle.hit};
      end
    endcase
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  always_comb begin
    count_next = count;
    if (item_valid) begin
      count_next = count_next + (QAW+1)'(res_count);
    end
    if (dst_take) begin
      count_next = count_next - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (item_valid) begin
        mode   <= mode_next;
        wr_ptr <= wr_ptr + QAW'(res_count);
      end
      if (dst_take) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && res_count != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (item_valid && res_count == 2'd2) begin
      queue[wr_ptr + QAW'(1)] <= res1;
    end
  end

endmodule

// File: rtl/jtl_checker.sv
// ----------------------------------------------------------------------------
// JSON token lexer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jtl_checker
  import jtl_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     dst_valid,
  input logic     dst_stall,
  input lex_out_t dst_item
);

  // A result was waiting under a stall at the previous edge, outside reset.
  logic dst_held;
  // An open token is a string or number token that carries a byte.
  logic open_ok;
  // Token kinds that never carry text.
  logic no_text_kind;

  always_ff @(posedge clk) begin
    dst_held <= !rst && dst_valid && dst_stall;
  end

  assign open_ok      = dst_item.has_byte &&
                        (dst_item.token_type == TT_STRING ||
                         dst_item.token_type == TT_NUMBER);
  assign no_text_kind = dst_item.token_type == TT_EOF ||
                        dst_item.token_type == TT_ERROR ||
                        dst_item.token_type == TT_UNDEF;

  // A stalled result stays and does not change.
  `CHK_SAME(a_dst_hold, clk, rst, dst_held, dst_valid && $stable(dst_item))

  // Reset leaves no result behind.
  `CHK_NEXT(a_reset_empty, clk, rst, !dst_valid)

  // A result without a character carries a zero byte.
  `CHK_SAME(a_byte_zero, clk, rst, dst_valid && !dst_item.has_byte, dst_item.text_byte == 8'h00)

  // Only string and number tokens stay open, and an open token carries a byte.
  `CHK_SAME(a_open_token, clk, rst, dst_valid && !dst_item.token_done, open_ok)

  // End of file, error and undefined tokens carry no character.
  `CHK_SAME(a_no_text, clk, rst, dst_valid && no_text_kind, !dst_item.has_byte && dst_item.token_done)

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (.*);

// File: dv/json_token_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token lexer testbench
// Drives bytes and end marks into the lexer with random gaps and output
// stalls, predicts every token result in a local model of the lexer mode and
// checks each result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module json_token_lexer_tb;
  import jtl_pkg::*;

  // Slowest legal run is roughly 800 items; the cycle limit leaves plenty of
  // margin on top of that.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 750;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  lex_in_t  src_item = '0;
  logic     dst_valid;
  logic     dst_stall = 1'b0;
  lex_out_t dst_item;

  // Local copy of the lexer mode, advanced on every accepted item.
  lex_mode_t   pred_mode = MODE_IDLE;
  // Token results predicted but not yet seen on the output, oldest first.
  lex_out_t    expected_tokens[$];
  lex_out_t    exp_tok;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int          stall_hold  = 0;
  // When set, neither side inserts gaps or stalls.
  bit          no_idle     = 1'b0;

  json_token_lexer i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic bit is_dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic lex_out_t make_tok(input token_type_t t, input logic [7:0] b,
                                        input logic has, input logic done);
    lex_out_t r;
    r.token_type = t;
    r.text_byte  = has ? b : 8'h00;
    r.has_byte   = has;
    r.token_done = done;
    r.last       = 1'b0;
    return r;
  endfunction

  // Lexes a byte that arrives with no token open. Returns 1 when it gives a
  // result; may move the mode into a string or a number.
  function automatic bit lex_start(input logic [7:0] c, input logic end_mark,
                                   output lex_out_t tok);
    tok = make_tok(TT_UNDEF, c, 1'b0, 1'b1);
    if (end_mark) begin
      tok = make_tok(TT_EOF, c, 1'b0, 1'b1);
      return 1'b1;
    end
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b0;
      CH_QUOTE: begin
        pred_mode = MODE_STR;
        return 1'b0;
      end
      CH_LBRACE: tok = make_tok(TT_LBRACE, c, 1'b1, 1'b1);
      CH_RBRACE: tok = make_tok(TT_RBRACE, c, 1'b1, 1'b1);
      CH_LBRACK: tok = make_tok(TT_LBRACKET, c, 1'b1, 1'b1);
      CH_RBRACK: tok = make_tok(TT_RBRACKET, c, 1'b1, 1'b1);
      CH_COMMA:  tok = make_tok(TT_COMMA, c, 1'b1, 1'b1);
      CH_COLON:  tok = make_tok(TT_COLON, c, 1'b1, 1'b1);
      default: begin
        if (is_dec_digit(c)) begin
          pred_mode = MODE_INT;
          tok       = make_tok(TT_NUMBER, c, 1'b1, 1'b0);
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic int predict_tokens(input lex_in_t it);
    lex_out_t toks[2];
    lex_out_t tok;
    int       n;
    n = 0;
    case (pred_mode)
      MODE_STR: begin
        if (it.at_end) begin
          pred_mode = MODE_IDLE;
          toks[n] = make_tok(TT_ERROR, 8'h00, 1'b0, 1'b1);
          n++;
        end else if (it.in_byte == CH_QUOTE) begin
          pred_mode = MODE_IDLE;
          toks[n] = make_tok(TT_STRING, 8'h00, 1'b0, 1'b1);
          n++;
        end else begin
          toks[n] = make_tok(TT_STRING, it.in_byte, 1'b1, 1'b0);
          n++;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (!it.at_end && is_dec_digit(it.in_byte)) begin
          toks[n] = make_tok(TT_NUMBER, it.in_byte, 1'b1, 1'b0);
          n++;
        end else if (!it.at_end && it.in_byte == CH_DOT && pred_mode == MODE_INT) begin
          pred_mode = MODE_FRAC;
          toks[n] = make_tok(TT_NUMBER, it.in_byte, 1'b1, 1'b0);
          n++;
        end else begin
          // The number closes, then the same item is lexed from scratch.
          pred_mode = MODE_IDLE;
          toks[n] = make_tok(TT_NUMBER, 8'h00, 1'b0, 1'b1);
          n++;
          if (lex_start(it.in_byte, it.at_end, tok)) begin
            toks[n] = tok;
            n++;
          end
        end
      end
      default: begin
        if (lex_start(it.in_byte, it.at_end, tok)) begin
          toks[n] = tok;
          n++;
        end
      end
    endcase
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Idling on both sides
  // --------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : stall_drive
    int len;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (dst_stall) begin
      dst_stall  <= 1'b0;
      stall_hold <= int'($urandom_range(0, 6));
    end else begin
      len = pick_gap();
      if (len != 0) begin
        dst_stall  <= 1'b1;
        stall_hold <= len - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: token_type %0d text_byte %02h",
               dst_item.token_type, dst_item.text_byte);
        err_count++;
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (dst_item.token_type !== exp_tok.token_type) begin
          $error("token_type: expected %0d, actual %0d",
                 exp_tok.token_type, dst_item.token_type);
          err_count++;
        end
        if (dst_item.text_byte !== exp_tok.text_byte) begin
          $error("text_byte: expected %02h, actual %02h",
                 exp_tok.text_byte, dst_item.text_byte);
          err_count++;
        end
        if (dst_item.has_byte !== exp_tok.has_byte) begin
          $error("has_byte: expected %0b, actual %0b", exp_tok.has_byte, dst_item.has_byte);
          err_count++;
        end
        if (dst_item.token_done !== exp_tok.token_done) begin
          $error("token_done: expected %0b, actual %0b",
                 exp_tok.token_done, dst_item.token_done);
          err_count++;
        end
        if (dst_item.last !== exp_tok.last) begin
          $error("last: expected %0b, actual %0b", exp_tok.last, dst_item.last);
          err_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Presents one item, holds it until accepted, then maybe idles. Valid stays
  // high when no gap follows, so back-to-back items never drop it.
  task automatic send_item(input logic [7:0] b, input logic end_mark, output int n_res);
    lex_in_t it;
    int      gap;
    it.in_byte = b;
    it.at_end  = end_mark;
    src_item  <= it;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    n_res = predict_tokens(it);
    gap   = pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      src_item  <= lex_in_t'(9'($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int n;
    send_item(b, 1'b0, n);
  endtask

  task automatic send_end(input logic [7:0] b);
    int n;
    send_item(b, 1'b1, n);
  endtask

  // Sender holds off until every predicted result has left the block.
  task automatic wait_drained();
    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_punctuation();
    send_byte(CH_LBRACE);
    send_byte(CH_SPACE);
    send_byte(CH_RBRACE);
    send_byte(CH_LF);
    send_byte(CH_LBRACK);
    send_byte(CH_CR);
    send_byte(CH_RBRACK);
    send_byte(CH_COMMA);
    send_byte(CH_COLON);
  endtask

  task automatic test_strings();
    // Extreme bytes pass through a string unchanged.
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    // An empty string gives only its closing result.
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    // End of input inside a string gives an error and no EOF.
    send_byte(CH_QUOTE);
    send_end(8'h00);
  endtask

  task automatic test_numbers();
    // A second dot closes the number and comes back as an undefined token.
    send_byte(CH_ZERO);
    send_byte(CH_NINE);
    send_byte(CH_DOT);
    send_byte(8'h35);
    send_byte(CH_DOT);
    // Whitespace closes a number and the close carries last.
    send_byte(8'h37);
    send_byte(CH_TAB);
    // A comma closes a number and then gives its own token.
    send_byte(8'h33);
    send_byte(CH_COMMA);
    // End of input closes a number and then gives EOF.
    send_byte(8'h38);
    send_end(8'h5A);
  endtask

  task automatic test_undefined_and_eof();
    send_byte(8'h80);
    send_end(8'hFF);
  endtask

  task automatic test_sender_pause();
    send_byte(CH_LBRACK);
    send_byte(8'h31);
    wait_drained();
    send_byte(CH_RBRACK);
    wait_drained();
  endtask

  // Mostly well-formed JSON fragments with random content, with stray bytes
  // and end marks mixed in. Whitespace outside strings counts only if it closes a number.
  task automatic test_random_documents();
    int          n;
    int          r;
    int          len;
    int unsigned counted;
    logic [7:0]  b;
    logic [7:0]  punct[6];
    logic [7:0]  blank[4];
    punct   = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON};
    blank   = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 100 < 2) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_item(CH_QUOTE, 1'b0, n);
        counted++;
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE) b = 8'h5C;
          send_item(b, 1'b0, n);
          counted++;
        end
        if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b1, n);
        else send_item(CH_QUOTE, 1'b0, n);
        counted++;
      end else if (r < 55) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, n);
          counted++;
        end
        if ($urandom_range(0, 1) == 0) begin
          send_item(CH_DOT, 1'b0, n);
          counted++;
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++) begin
            send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, n);
            counted++;
          end
          if ($urandom_range(0, 9) == 0) begin
            send_item(CH_DOT, 1'b0, n);
            counted++;
          end
        end
      end else if (r < 80) begin
        send_item(punct[$urandom_range(0, 5)], 1'b0, n);
        counted++;
      end else if (r < 88) begin
        send_item(blank[$urandom_range(0, 3)], 1'b0, n);
        if (n > 0) counted++;
      end else if (r < 95) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, n);
        if (n > 0) counted++;
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1, n);
        counted++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_punctuation();
    test_strings();
    test_numbers();
    test_undefined_and_eof();
    test_sender_pause();
    test_random_documents();
    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d predicted results never arrived", expected_tokens.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
